// ===== src/tts_pkg.sv =====
// shared types, constants and digit encoding for the temperature display scanner
package tts_pkg;

  localparam int unsigned NumPos = 8;
  localparam int unsigned PosW   = $clog2(NumPos);
  localparam int unsigned RawW   = 12;
  localparam int unsigned SegW   = 8;

  localparam logic [SegW-1:0] SegBlank = 8'h00;
  localparam logic [SegW-1:0] SegMinus = 8'h40;
  localparam logic [SegW-1:0] SegDp    = 8'h80;
  localparam logic [SegW-1:0] SegReset = 8'h3F;

  // reciprocals for division of a 14 bit value by 10, 100 and 1000
  localparam logic [14:0] RecipTen      = 15'd26215;  // 2^18 / 10, rounded up
  localparam logic [14:0] RecipHundred  = 15'd20972;  // 2^21 / 100, rounded up
  localparam logic [14:0] RecipThousand = 15'd16778;  // 2^24 / 1000, rounded up

  typedef logic [NumPos-1:0][SegW-1:0] seg_row_t;

  typedef struct packed {
    logic load;
    logic tick;
  } ctrl_t;

  typedef struct packed {
    logic [PosW-1:0] sel;
    logic [SegW-1:0] seg;
  } rd_t;

  function automatic logic [SegW-1:0] digit_code(input logic [3:0] d);
    logic [SegW-1:0] c;
    case (d)
      4'd0:    c = 8'h3F;
      4'd1:    c = 8'h06;
      4'd2:    c = 8'h5B;
      4'd3:    c = 8'h4F;
      4'd4:    c = 8'h66;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h7D;
      4'd7:    c = 8'h07;
      4'd8:    c = 8'h7F;
      4'd9:    c = 8'h6F;
      default: c = SegBlank;
    endcase
    return c;
  endfunction

endpackage

// ===== src/tts_in_if.sv =====
// input channel: load or scan tick word
interface tts_in_if;
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic signed [11:0]    raw_reading;

  modport source (output valid, output func, output raw_reading, input ready);
  modport sink   (input valid, input func, input raw_reading, output ready);
endinterface

// ===== src/tts_out_if.sv =====
// output channel: digit select and segment word
interface tts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] digit_select;
  logic [7:0] segments;

  modport source (output valid, output digit_select, output segments, input ready);
  modport sink   (input valid, input digit_select, input segments, output ready);
endinterface

// ===== src/temp_to_seven_segment_scanner.sv =====
// top level of the multiplexed seven-segment temperature display scanner
//
//   channel  dir  word fields                  result
//   in_i     in   func, raw_reading            load: none, tick: one word
//   out_o    out  digit_select, segments       one word per tick
//
// a word is held in the input register, then a load updates the store
// and a tick fills the output register; one word per cycle sustained
// unless a tick stalls; a tick reaches out_o through the input register
// and then the output register, and a load is done when it writes the store;
// a tick waiting on a full output register holds the input register; loads never wait
// reset sets every store entry to the zero pattern and the scan position to 0
module temp_to_seven_segment_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  tts_in_if.sink      in_i,
  tts_out_if.source   out_o
);
  import tts_pkg::*;

  logic              s1_valid_q;
  logic              s1_func_q;
  logic signed [11:0] s1_raw_q;
  logic              out_valid_q;
  logic [PosW-1:0]   out_sel_q;
  logic [SegW-1:0]   out_seg_q;
  logic              out_free;
  logic              s1_go;
  ctrl_t             ctrl;
  seg_row_t          row;
  rd_t               rd;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_go      = s1_valid_q && (!s1_func_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign ctrl.load  = s1_go && !s1_func_q;
  assign ctrl.tick  = s1_go && s1_func_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_func_q <= in_i.func;
      s1_raw_q  <= in_i.raw_reading;
    end
  end

  tts_conv u_conv (
    .raw_i (s1_raw_q),
    .row_o (row)
  );

  tts_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .row_i  (row),
    .rd_o   (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.tick) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.tick) begin
      out_sel_q <= rd.sel;
      out_seg_q <= rd.seg;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digit_select = out_sel_q;
  assign out_o.segments     = out_seg_q;

  a_tick_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_func_q && !out_free |=> s1_valid_q && s1_func_q)
    else $error("blocked tick left the input register");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.tick |=> out_valid_q && out_sel_q == $past(rd.sel))
    else $error("tick did not load the output register");

  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.tick && $past(ctrl.tick) |-> rd.sel == PosW'($past(rd.sel) - PosW'(1)))
    else $error("scan position did not advance by one");

endmodule

// ===== src/tts_conv.sv =====
// reading to segment row conversion: magnitude, scaling, decimal digits
module tts_conv (
  input  logic signed [11:0] raw_i,
  output tts_pkg::seg_row_t  row_o
);
  import tts_pkg::*;

  logic        neg;
  logic [11:0] mag;
  logic [16:0] v_full;
  logic [13:0] v;
  logic [28:0] p_ten;
  logic [28:0] p_hun;
  logic [28:0] p_tho;
  logic [10:0] q_ten;
  logic [7:0]  q_hun;
  logic [3:0]  q_tho;
  logic [13:0] t_units;
  logic [10:0] t_tens;
  logic [7:0]  t_huns;
  logic [3:0]  d_units;
  logic [3:0]  d_tens;
  logic [3:0]  d_huns;
  logic [3:0]  d_thos;
  logic [3:0]  d_tths;

  assign neg = raw_i[11];
  // -2048 wraps to 0x800, which is the wanted magnitude
  assign mag = neg ? (~raw_i + 12'd1) : raw_i;

  assign v_full = 17'(mag) * 17'd25 + 17'd2;
  assign v      = v_full[15:2];

  assign p_ten = 29'(v) * 29'(RecipTen);
  assign p_hun = 29'(v) * 29'(RecipHundred);
  assign p_tho = 29'(v) * 29'(RecipThousand);

  assign q_ten = p_ten[28:18];
  assign q_hun = p_hun[28:21];
  assign q_tho = p_tho[27:24];

  assign t_units = v - 14'(q_ten) * 14'd10;
  assign t_tens  = q_ten - 11'(q_hun) * 11'd10;
  assign t_huns  = q_hun - 8'(q_tho) * 8'd10;

  assign d_units = t_units[3:0];
  assign d_tens  = t_tens[3:0];
  assign d_huns  = t_huns[3:0];
  assign d_thos  = (q_tho >= 4'd10) ? (q_tho - 4'd10) : q_tho;
  assign d_tths  = (v >= 14'd10000) ? 4'd1 : 4'd0;

  always_comb begin
    row_o[0] = SegBlank;
    row_o[1] = SegBlank;
    row_o[2] = neg ? SegMinus : SegBlank;
    row_o[3] = digit_code(d_tths);
    row_o[4] = digit_code(d_thos);
    row_o[5] = digit_code(d_huns) | SegDp;
    row_o[6] = digit_code(d_tens);
    row_o[7] = digit_code(d_units);
  end

endmodule

// ===== src/tts_store.sv =====
// segment store and scan position
module tts_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tts_pkg::ctrl_t    ctrl_i,
  input  tts_pkg::seg_row_t row_i,
  output tts_pkg::rd_t      rd_o
);
  import tts_pkg::*;

  logic [SegW-1:0] store_q [NumPos];
  logic [PosW-1:0] pos_q;
  logic [PosW-1:0] pos_d;

  assign pos_d = ctrl_i.tick ? (pos_q + PosW'(1)) : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPos; i++) store_q[i] <= SegReset;
      pos_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        for (int i = 0; i < NumPos; i++) store_q[i] <= row_i[i];
      end
      pos_q <= pos_d;
    end
  end

  // select code is 7 minus position
  assign rd_o.sel = ~pos_q;
  assign rd_o.seg = store_q[pos_q];

endmodule

// ===== tb/tb_tts_pkg.sv =====
// word codes shared by the scanner testbench stimulus and checker
package tb_tts_pkg;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncTick = 1'b1;

endpackage

// ===== tb/tb_tts_checker.sv =====
// display store predictor and scan word checker for the temperature display scanner
module tb_tts_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tts_in_if           in_mon,
  tts_out_if          out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  import tts_pkg::*;
  import tb_tts_pkg::*;

  typedef struct packed {
    logic [PosW-1:0] sel;
    logic [SegW-1:0] seg;
  } scan_word_t;

  logic [SegW-1:0] disp_mem [NumPos];
  logic [PosW-1:0] scan_pos;
  scan_word_t      scan_words_q [$];
  int unsigned     mismatches;

  function automatic logic [SegW-1:0] seg_of_digit(input int d);
    logic [SegW-1:0] s;
    case (d)
      0:       s = 8'h3F;
      1:       s = 8'h06;
      2:       s = 8'h5B;
      3:       s = 8'h4F;
      4:       s = 8'h66;
      5:       s = 8'h6D;
      6:       s = 8'h7D;
      7:       s = 8'h07;
      8:       s = 8'h7F;
      default: s = 8'h6F;
    endcase
    return s;
  endfunction

  // sixteenths of a degree to hundredths, rounded half up
  function automatic void apply_reading(input logic signed [RawW-1:0] r);
    int mag;
    int hundredths;
    mag = (r < 0) ? -int'(r) : int'(r);
    hundredths = (25 * mag + 2) / 4;
    disp_mem[0] = SegBlank;
    disp_mem[1] = SegBlank;
    disp_mem[2] = (r < 0) ? SegMinus : SegBlank;
    disp_mem[3] = seg_of_digit((hundredths / 10000) % 10);
    disp_mem[4] = seg_of_digit((hundredths / 1000) % 10);
    disp_mem[5] = seg_of_digit((hundredths / 100) % 10) | SegDp;
    disp_mem[6] = seg_of_digit((hundredths / 10) % 10);
    disp_mem[7] = seg_of_digit(hundredths % 10);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_word_t exp_w;
    scan_word_t pred_w;
    if (!rst_ni) begin
      for (int i = 0; i < NumPos; i++) disp_mem[i] = SegReset;
      scan_pos = '0;
      scan_words_q.delete();
      mismatches = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (scan_words_q.size() == 0) begin
          $error("unexpected word: digit_select %0d segments %h",
                 out_mon.digit_select, out_mon.segments);
          mismatches++;
        end else begin
          exp_w = scan_words_q.pop_front();
          if (out_mon.digit_select !== exp_w.sel) begin
            $error("digit_select: expected %0d, got %0d", exp_w.sel, out_mon.digit_select);
            mismatches++;
          end
          if (out_mon.segments !== exp_w.seg) begin
            $error("segments: expected %h, got %h", exp_w.seg, out_mon.segments);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.func == FuncTick) begin
          pred_w.sel = PosW'(NumPos - 1) - scan_pos;
          pred_w.seg = disp_mem[scan_pos];
          scan_words_q.push_back(pred_w);
          scan_pos = scan_pos + 1'b1;
        end else begin
          apply_reading(in_mon.raw_reading);
        end
      end
      fail_cnt_o <= mismatches;
      pending_o <= scan_words_q.size();
    end
  end

endmodule

// ===== tb/tb_temp_to_seven_segment_scanner.sv =====
// stimulus, flow control and verdict for the temperature display scanner
module tb_temp_to_seven_segment_scanner;
  import tb_tts_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned NumRandom  = 1300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned cyc_cnt = 0;
  int unsigned snd_idle = 9;
  int unsigned rcv_idle = 46;
  int unsigned hold_cnt = 0;
  logic        hold_tgl = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned fail_cnt;
  int unsigned pending;

  tts_in_if  in_if ();
  tts_out_if out_if ();

  temp_to_seven_segment_scanner uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  tb_tts_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CycleLimit) begin
      $display("tb_temp_to_seven_segment_scanner: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_cnt <= HoldCycles;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  task automatic send_word(input logic f, input logic signed [11:0] r);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func <= f;
    in_if.raw_reading <= r;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_word(FuncTick, 12'($urandom));
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.func = FuncLoad;
    in_if.raw_reading = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pattern, most negative, zero, most positive, minus one
    send_ticks(8);
    send_word(FuncLoad, -12'sd2048);
    send_ticks(8);
    send_word(FuncLoad, 12'sd0);
    send_ticks(4);
    send_word(FuncLoad, 12'sd2047);
    send_ticks(2);
    send_word(FuncLoad, -12'sd1);
    send_ticks(4);

    hold_tgl <= ~hold_tgl;
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) begin
        snd_idle = 46;
        rcv_idle <= 9;
      end
      if (n == 2 * NumRandom / 3) begin
        snd_idle = 0;
        rcv_idle <= 0;
        hold_tgl <= ~hold_tgl;
      end
      if ($urandom_range(0, 9) < 3) send_word(FuncLoad, 12'($urandom));
      else send_word(FuncTick, 12'($urandom));
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_temp_to_seven_segment_scanner: PASS");
    end else begin
      $display("tb_temp_to_seven_segment_scanner: FAIL");
    end
    $finish;
  end

endmodule
